// ===== design/two_class_buffer_pool_allocator_assert.svh =====
// assertion macros for the buffer pool allocator
`ifndef TWO_CLASS_BUFFER_POOL_ALLOCATOR_ASSERT_SVH
`define TWO_CLASS_BUFFER_POOL_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent in a cycle implies consequent in the same cycle
`define TCBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// antecedent in a cycle implies consequent in the next cycle
`define TCBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define TCBPA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TCBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/tcbpa_pkg.sv =====
package tcbpa_pkg;

	localparam int NORMAL_SLOTS   = 16;
	localparam int EXTENDED_SLOTS = 4;
	localparam int TOTAL_SLOTS    = NORMAL_SLOTS + EXTENDED_SLOTS;
	localparam int ADDR_W         = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

	localparam int CMD_W   = 2;
	localparam int SIZE_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int TICK_W  = 32;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	localparam logic [SIZE_W-1:0] NORMAL_SIZE_LIMIT_RST = 16'd256;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST     = 32'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_SWEEP = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_SIZE_LIMIT = 2'd0,
		REG_TIMEOUT_TICKS     = 2'd1
	} reg_idx_t;

endpackage

// ===== design/tcbpa_ifs.sv =====
interface tcbpa_in_if import tcbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [SIZE_W-1:0] request_size;
	logic              pool_select;
	logic [SLOT_W-1:0] slot_index;
	logic [TICK_W-1:0] now_tick;

	modport source (output valid, cmd, request_size, pool_select, slot_index, now_tick,
		input ready);
	modport sink (input valid, cmd, request_size, pool_select, slot_index, now_tick,
		output ready);
endinterface

interface tcbpa_out_if import tcbpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic              granted_pool;
	logic [SLOT_W-1:0] granted_slot;
	logic [TICK_W-1:0] hold_ticks;
	logic [CNT_W-1:0]  expired_count;

	modport source (output valid, ok, granted_pool, granted_slot, hold_ticks, expired_count,
		input ready);
	modport sink (input valid, ok, granted_pool, granted_slot, hold_ticks, expired_count,
		output ready);
endinterface

// ===== design/two_class_buffer_pool_allocator.sv =====
// steps: alloc and cmd 3 pass S_EXEC then S_FINISH; free passes S_EXEC, S_READ and S_FINISH,
// or S_EXEC and S_FINISH when refused; sweep passes S_EXEC, S_SWEEP once per slot, then S_FINISH
// throughput: one item at a time; a sweep is set by the stamp memory read port,
// which visits one stored stamp per cycle
// the next item is taken as soon as the result sits in the output register
// reset (arst_n low, asynchronous): every slot free, registers back to 256 and 1000,
// no result pending; stamp memory is not cleared
`include "two_class_buffer_pool_allocator_assert.svh"

module two_class_buffer_pool_allocator import tcbpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tcbpa_in_if.sink             req,
	tcbpa_out_if.source          rsp
);

	// one-hot sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_READ   = 5'b00100,
		S_SWEEP  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [SIZE_W-1:0] limit_q;
	logic [TICK_W-1:0] timeout_q;

	// free map: normal slots at 0.., extended slots follow them
	logic [TOTAL_SLOTS-1:0] free_q;

	// latched item
	cmd_t              cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic              pool_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TICK_W-1:0] now_q;

	// result under construction
	logic              res_ok_q;
	logic              res_pool_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [TICK_W-1:0] res_hold_q;
	logic [CNT_W-1:0]  res_cnt_q;

	// sweep position and the free address of the pending free
	logic [ADDR_W-1:0] sw_q;
	logic [ADDR_W-1:0] faddr_q;

	// output register
	logic              out_valid_q;
	logic              out_ok_q;
	logic              out_pool_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TICK_W-1:0] out_hold_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// stamp memory, one port written, one read with registered data
	logic [TICK_W-1:0] stamp_mem [TOTAL_SLOTS];
	logic [TICK_W-1:0] stamp_rd_s1;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;

	// lowest-free search per pool
	logic              norm_hit;
	logic [ADDR_W-1:0] norm_idx;
	logic              ext_hit;
	logic [ADDR_W-1:0] ext_idx;
	logic              use_ext;
	logic              alloc_hit;
	logic [ADDR_W-1:0] alloc_off;
	logic [ADDR_W-1:0] alloc_addr;

	// free handle check
	logic              free_in_range;
	logic [ADDR_W-1:0] free_addr;
	logic              free_ok;

	// sweep step
	logic              sw_last;
	logic              age_hit;
	logic              fin_go;
	logic              acc;

	assign acc    = req.valid && req.ready;
	assign fin_go = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid         = out_valid_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.granted_pool  = out_pool_q;
	assign rsp.granted_slot  = out_slot_q;
	assign rsp.hold_ticks    = out_hold_q;
	assign rsp.expired_count = out_cnt_q;

	// priority encoders, lowest index wins
	always_comb begin
		norm_hit = 1'b0;
		norm_idx = '0;
		for (int k = NORMAL_SLOTS - 1; k >= 0; k--) begin
			if (free_q[k]) begin
				norm_hit = 1'b1;
				norm_idx = ADDR_W'(k);
			end
		end
	end

	always_comb begin
		ext_hit = 1'b0;
		ext_idx = '0;
		for (int k = EXTENDED_SLOTS - 1; k >= 0; k--) begin
			if (free_q[NORMAL_SLOTS + k]) begin
				ext_hit = 1'b1;
				ext_idx = ADDR_W'(k);
			end
		end
	end

	// larger than the limit goes to the extended pool, no fallback
	assign use_ext    = size_q > limit_q;
	assign alloc_hit  = use_ext ? ext_hit : norm_hit;
	assign alloc_off  = use_ext ? ext_idx : norm_idx;
	assign alloc_addr = use_ext ? ADDR_W'(NORMAL_SLOTS + int'(ext_idx)) : norm_idx;

	// the handle must be in its pool and currently held
	assign free_in_range = pool_q ? (int'(idx_q) < EXTENDED_SLOTS)
		: (int'(idx_q) < NORMAL_SLOTS);
	assign free_addr     = pool_q ? ADDR_W'(NORMAL_SLOTS + int'(idx_q)) : ADDR_W'(idx_q);
	assign free_ok       = free_in_range && !free_q[free_addr];

	// age is now minus stamp, wrapping; strictly above timeout counts
	assign sw_last = (sw_q == ADDR_W'(TOTAL_SLOTS - 1));
	assign age_hit = !free_q[sw_q] && ((now_q - stamp_rd_s1) > timeout_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = alloc_addr;
		mem_raddr = free_addr;
		case (state_q)
			S_EXEC: begin
				mem_we = (cmd_q == CMD_ALLOC) && alloc_hit;
				if (cmd_q == CMD_SWEEP) begin
					mem_raddr = '0;
				end
			end
			S_SWEEP: begin
				// prefetch the next stamp while the current one is judged
				mem_raddr = sw_last ? '0 : sw_q + 1'b1;
			end
			default: begin
				mem_raddr = free_addr;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[mem_waddr] <= now_q;
		end
		stamp_rd_s1 <= stamp_mem[mem_raddr];
	end

	// configuration writes, ignored past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= NORMAL_SIZE_LIMIT_RST;
			timeout_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_SIZE_LIMIT: limit_q   <= cfg_wdata[SIZE_W-1:0];
				REG_TIMEOUT_TICKS:     timeout_q <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q  <= cmd_t'(req.cmd);
			size_q <= req.request_size;
			pool_q <= req.pool_select;
			idx_q  <= req.slot_index;
			now_q  <= req.now_tick;
		end
	end

	// sequencer and free map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= '1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_ALLOC: begin
							if (alloc_hit) begin
								free_q[alloc_addr] <= 1'b0;
							end
							state_q <= S_FINISH;
						end
						CMD_FREE: begin
							state_q <= free_ok ? S_READ : S_FINISH;
						end
						CMD_SWEEP: begin
							state_q <= S_SWEEP;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_READ: begin
					free_q[faddr_q] <= 1'b1;
					state_q         <= S_FINISH;
				end
				S_SWEEP: begin
					// reclaim the timed-out slot
					if (age_hit) begin
						free_q[sw_q] <= 1'b1;
					end
					if (sw_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields and sweep position
	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				// a granted alloc and every sweep succeed, a free is settled later
				res_ok_q   <= ((cmd_q == CMD_ALLOC) && alloc_hit) || (cmd_q == CMD_SWEEP);
				res_pool_q <= (cmd_q == CMD_ALLOC) && alloc_hit && use_ext;
				res_slot_q <= ((cmd_q == CMD_ALLOC) && alloc_hit) ? SLOT_W'(alloc_off) : '0;
				res_hold_q <= '0;
				res_cnt_q  <= '0;
				sw_q       <= '0;
				faddr_q    <= free_addr;
			end
			S_READ: begin
				res_ok_q   <= 1'b1;
				res_hold_q <= now_q - stamp_rd_s1;
			end
			S_SWEEP: begin
				if (age_hit && (res_cnt_q != CNT_MAX)) begin
					res_cnt_q <= res_cnt_q + 1'b1;
				end
				sw_q <= sw_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register, freed when the sink takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_ok_q   <= res_ok_q;
			out_pool_q <= res_pool_q;
			out_slot_q <= res_slot_q;
			out_hold_q <= res_hold_q;
			out_cnt_q  <= res_cnt_q;
		end
	end

	// an accepted item always enters execution next
	`TCBPA_ASSERT_NEXT(a_accept_exec, clk, arst_n, acc, state_q == S_EXEC)
	// the last sweep step hands over to the finishing stage
	`TCBPA_ASSERT_NEXT(a_sweep_ends, clk, arst_n, (state_q == S_SWEEP) && sw_last, state_q == S_FINISH)
	// a granted slot is marked held afterwards
	`TCBPA_ASSERT_NEXT(a_alloc_held, clk, arst_n, mem_we, !free_q[$past(alloc_addr)])
	// the allocator never takes the next item while a sweep or a free is in flight
	`TCBPA_ASSERT_NOW(a_ready_idle, clk, arst_n, req.ready, !(state_q == S_SWEEP) && !(state_q == S_READ))

endmodule
